/* rtl/core/cau_pkg.sv */
// shared types, codes and helpers for the complex arithmetic unit
package cau_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int WideBits = 2 * WordBits + 1;
  localparam int DivSteps = WordBits;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  localparam logic [WordBits-1:0] WORD_MAX = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic [WordBits-1:0] WORD_MIN = {1'b1, {(WordBits-1){1'b0}}};
  localparam logic signed [WideBits-1:0] WIDE_MAX =
    $signed({{(WordBits+1){1'b0}}, WORD_MAX});
  localparam logic signed [WideBits-1:0] WIDE_MIN =
    $signed({{(WordBits+1){1'b1}}, WORD_MIN});

  // common part of a transaction as it travels down the pipe
  typedef struct packed {
    logic                  is_div;
    logic                  dbz;
    logic                  ovf;
    logic [WordBits-1:0]   re;
    logic [WordBits-1:0]   im;
    logic [2*WordBits-1:0] den;
  } ctrl_t;

  // one restoring divider lane
  typedef struct packed {
    logic                  big;
    logic                  neg;
    logic [2*WordBits-1:0] rem;
    logic [WordBits-1:0]   low;
    logic [WordBits-1:0]   quo;
  } div_lane_t;

  // saturate a wide signed value to one word, msb of result is the overflow flag
  function automatic logic [WordBits:0] sat_wide(logic signed [WideBits-1:0] v);
    logic [WordBits:0] r;
    if (v > WIDE_MAX) begin
      r = {1'b1, WORD_MAX};
    end else if (v < WIDE_MIN) begin
      r = {1'b1, WORD_MIN};
    end else begin
      r = {1'b0, v[WordBits-1:0]};
    end
    return r;
  endfunction

  // one quotient bit per call
  function automatic div_lane_t div_step(div_lane_t l, logic [2*WordBits-1:0] den);
    div_lane_t           r;
    logic [2*WordBits:0] t;
    r = l;
    t = {l.rem, l.low[WordBits-1]};
    if (t >= {1'b0, den}) begin
      r.rem = (2*WordBits)'(t - {1'b0, den});
      r.quo = {l.quo[WordBits-2:0], 1'b1};
    end else begin
      r.rem = t[2*WordBits-1:0];
      r.quo = {l.quo[WordBits-2:0], 1'b0};
    end
    r.low = {l.low[WordBits-2:0], 1'b0};
    return r;
  endfunction

  // final quotient to signed word, msb of result is the overflow flag
  function automatic logic [WordBits:0] div_result(div_lane_t l);
    logic [WordBits:0] r;
    if (l.big) begin
      r = {1'b1, l.neg ? WORD_MIN : WORD_MAX};
    end else if (l.neg) begin
      if (l.quo > WORD_MIN) r = {1'b1, WORD_MIN};
      else r = {1'b0, WordBits'(~l.quo + 1'b1)};
    end else begin
      if (l.quo > WORD_MAX) r = {1'b1, WORD_MAX};
      else r = {1'b0, l.quo};
    end
    return r;
  endfunction

endpackage

/* rtl/core/cau_front.sv */
// products, sums and divider setup: three register stages
module cau_front import cau_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_i,
  input  logic [1:0]                 action_i,
  input  logic signed [WordBits-1:0] a_re_i,
  input  logic signed [WordBits-1:0] a_im_i,
  input  logic signed [WordBits-1:0] b_re_i,
  input  logic signed [WordBits-1:0] b_im_i,
  output logic                       vld_o,
  output ctrl_t                      ctrl_o,
  output div_lane_t                  re_o,
  output div_lane_t                  im_o
);

  // stage 1 registers
  logic                         v1_r;
  action_t                      act1_r, act1_nxt;
  logic                         dbz1_r, dbz1_nxt;
  logic signed [2*WordBits-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, sq_r_r, sq_i_r;
  logic signed [2*WordBits-1:0] p_rr_nxt, p_ii_nxt, p_ir_nxt, p_ri_nxt, sq_r_nxt, sq_i_nxt;
  logic signed [WordBits:0]     as_re_r, as_im_r, as_re_nxt, as_im_nxt;
  // stage 2 registers
  logic                         v2_r;
  action_t                      act2_r;
  logic                         dbz2_r;
  logic signed [WideBits-1:0]   x_re_r, x_im_r, x_re_nxt, x_im_nxt;
  logic [2*WordBits-1:0]        den_r, den_nxt;
  // stage 3 registers
  logic                         v3_r;
  ctrl_t                        ctrl_r, ctrl_nxt;
  div_lane_t                    re_r, im_r, re_nxt, im_nxt;

  // divider lane setup: magnitude of numerator scaled by 2^frac
  function automatic div_lane_t lane_prep(logic signed [WideBits-1:0] x,
                                          logic [2*WordBits-1:0] den);
    div_lane_t                     l;
    logic [2*WordBits-1:0]         mag;
    logic [2*WordBits+FracBits-1:0] num;
    mag    = x[WideBits-1] ? (2*WordBits)'(-x) : (2*WordBits)'(x);
    num    = {mag, {FracBits{1'b0}}};
    l.neg  = x[WideBits-1];
    l.big  = (2*WordBits)'(num[2*WordBits+FracBits-1:WordBits]) >= den;
    l.rem  = (2*WordBits)'(num[2*WordBits+FracBits-1:WordBits]);
    l.low  = num[WordBits-1:0];
    l.quo  = '0;
    return l;
  endfunction

  always_comb begin
    act1_nxt  = action_t'(action_i);
    dbz1_nxt  = (act1_nxt == ACT_DIV) && (b_re_i == '0) && (b_im_i == '0);
    p_rr_nxt  = a_re_i * b_re_i;
    p_ii_nxt  = a_im_i * b_im_i;
    p_ir_nxt  = a_im_i * b_re_i;
    p_ri_nxt  = a_re_i * b_im_i;
    sq_r_nxt  = b_re_i * b_re_i;
    sq_i_nxt  = b_im_i * b_im_i;
    if (act1_nxt == ACT_SUB) begin
      as_re_nxt = (WordBits+1)'(a_re_i) - (WordBits+1)'(b_re_i);
      as_im_nxt = (WordBits+1)'(a_im_i) - (WordBits+1)'(b_im_i);
    end else begin
      as_re_nxt = (WordBits+1)'(a_re_i) + (WordBits+1)'(b_re_i);
      as_im_nxt = (WordBits+1)'(a_im_i) + (WordBits+1)'(b_im_i);
    end
  end

  always_comb begin
    den_nxt = $unsigned(sq_r_r) + $unsigned(sq_i_r);
    case (act1_r)
      ACT_MUL: begin
        x_re_nxt = WideBits'(p_rr_r) - WideBits'(p_ii_r);
        x_im_nxt = WideBits'(p_ir_r) + WideBits'(p_ri_r);
      end
      ACT_DIV: begin
        x_re_nxt = WideBits'(p_rr_r) + WideBits'(p_ii_r);
        x_im_nxt = WideBits'(p_ir_r) - WideBits'(p_ri_r);
      end
      default: begin
        x_re_nxt = WideBits'(as_re_r);
        x_im_nxt = WideBits'(as_im_r);
      end
    endcase
  end

  always_comb begin
    logic [WordBits:0] s_re, s_im;
    if (act2_r == ACT_MUL) begin
      s_re = sat_wide(x_re_r >>> FracBits);
      s_im = sat_wide(x_im_r >>> FracBits);
    end else begin
      s_re = sat_wide(x_re_r);
      s_im = sat_wide(x_im_r);
    end
    ctrl_nxt.is_div = (act2_r == ACT_DIV);
    ctrl_nxt.dbz    = dbz2_r;
    ctrl_nxt.ovf    = s_re[WordBits] | s_im[WordBits];
    ctrl_nxt.re     = s_re[WordBits-1:0];
    ctrl_nxt.im     = s_im[WordBits-1:0];
    ctrl_nxt.den    = den_r;
    re_nxt          = lane_prep(x_re_r, den_r);
    im_nxt          = lane_prep(x_im_r, den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    act1_r  <= act1_nxt;
    dbz1_r  <= dbz1_nxt;
    p_rr_r  <= p_rr_nxt;
    p_ii_r  <= p_ii_nxt;
    p_ir_r  <= p_ir_nxt;
    p_ri_r  <= p_ri_nxt;
    sq_r_r  <= sq_r_nxt;
    sq_i_r  <= sq_i_nxt;
    as_re_r <= as_re_nxt;
    as_im_r <= as_im_nxt;
    act2_r  <= act1_r;
    dbz2_r  <= dbz1_r;
    x_re_r  <= x_re_nxt;
    x_im_r  <= x_im_nxt;
    den_r   <= den_nxt;
    ctrl_r  <= ctrl_nxt;
    re_r    <= re_nxt;
    im_r    <= im_nxt;
  end

  assign vld_o  = v3_r;
  assign ctrl_o = ctrl_r;
  assign re_o   = re_r;
  assign im_o   = im_r;

endmodule

/* rtl/core/cau_div_step.sv */
// one pipelined restoring division step for both result parts
module cau_div_step import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      vld_i,
  input  ctrl_t     ctrl_i,
  input  div_lane_t re_i,
  input  div_lane_t im_i,
  output logic      vld_o,
  output ctrl_t     ctrl_o,
  output div_lane_t re_o,
  output div_lane_t im_o
);

  logic      vld_r;
  ctrl_t     ctrl_r;
  div_lane_t re_r, im_r, re_nxt, im_nxt;

  always_comb begin
    re_nxt = div_step(re_i, ctrl_i.den);
    im_nxt = div_step(im_i, ctrl_i.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    ctrl_r <= ctrl_i;
    re_r   <= re_nxt;
    im_r   <= im_nxt;
  end

  assign vld_o  = vld_r;
  assign ctrl_o = ctrl_r;
  assign re_o   = re_r;
  assign im_o   = im_r;

endmodule

/* rtl/core/complex_arith_unit.sv */
// complex add, subtract, multiply and divide on signed q16.16 operands
// every action passes through the front stages, the quotient pipeline and the output register
// throughput: one transaction per cycle, busy is always low
// the 32 one-bit stages of the quotient pipeline make up most of the latency
// reset clears all valid bits; transactions in flight are dropped
module complex_arith_unit import cau_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_action,
  input  logic signed [WordBits-1:0] in_a_re,
  input  logic signed [WordBits-1:0] in_a_im,
  input  logic signed [WordBits-1:0] in_b_re,
  input  logic signed [WordBits-1:0] in_b_im,
  output logic                       out_valid,
  output logic signed [WordBits-1:0] out_res_re,
  output logic signed [WordBits-1:0] out_res_im,
  output logic                       out_overflow,
  output logic                       out_div_by_zero
);

  logic      vld  [DivSteps+1];
  ctrl_t     ctrl [DivSteps+1];
  div_lane_t re   [DivSteps+1];
  div_lane_t im   [DivSteps+1];

  logic                out_valid_r;
  logic [WordBits-1:0] res_re_r, res_re_nxt, res_im_r, res_im_nxt;
  logic                ovf_r, ovf_nxt, dbz_r, dbz_nxt;

  assign busy = 1'b0;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (start & ~busy),
    .action_i (in_action),
    .a_re_i   (in_a_re),
    .a_im_i   (in_a_im),
    .b_re_i   (in_b_re),
    .b_im_i   (in_b_im),
    .vld_o    (vld[0]),
    .ctrl_o   (ctrl[0]),
    .re_o     (re[0]),
    .im_o     (im[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    cau_div_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld[i]),
      .ctrl_i (ctrl[i]),
      .re_i   (re[i]),
      .im_i   (im[i]),
      .vld_o  (vld[i+1]),
      .ctrl_o (ctrl[i+1]),
      .re_o   (re[i+1]),
      .im_o   (im[i+1])
    );
  end

  always_comb begin
    logic [WordBits:0] q_re, q_im;
    ctrl_t             c;
    c    = ctrl[DivSteps];
    q_re = div_result(re[DivSteps]);
    q_im = div_result(im[DivSteps]);
    if (c.dbz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      ovf_nxt    = 1'b0;
      dbz_nxt    = 1'b1;
    end else if (c.is_div) begin
      res_re_nxt = q_re[WordBits-1:0];
      res_im_nxt = q_im[WordBits-1:0];
      ovf_nxt    = q_re[WordBits] | q_im[WordBits];
      dbz_nxt    = 1'b0;
    end else begin
      res_re_nxt = c.re;
      res_im_nxt = c.im;
      ovf_nxt    = c.ovf;
      dbz_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    res_re_r <= res_re_nxt;
    res_im_r <= res_im_nxt;
    ovf_r    <= ovf_nxt;
    dbz_r    <= dbz_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_res_re      = $signed(res_re_r);
  assign out_res_im      = $signed(res_im_r);
  assign out_overflow    = ovf_r;
  assign out_div_by_zero = dbz_r;

endmodule

/* rtl/core/cau_checker.sv */
// port-level checks for the complex arithmetic unit, bound to the top level
module cau_checker import cau_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [WordBits-1:0] out_res_re,
  input logic [WordBits-1:0] out_res_im,
  input logic                out_overflow,
  input logic                out_div_by_zero
);

  // every result traces back to a transaction a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 36))
    else $error("result without a matching transaction");

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_overflow && out_div_by_zero))
    else $error("overflow and divide by zero together");

  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_by_zero) |-> (out_res_re == '0 && out_res_im == '0))
    else $error("divide by zero with nonzero parts");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_res_re      (out_res_re),
  .out_res_im      (out_res_im),
  .out_overflow    (out_overflow),
  .out_div_by_zero (out_div_by_zero)
);

/* sim/complex_arith_unit_checker.sv */
// checker for the complex arithmetic unit: predicts each transaction and compares results
module complex_arith_unit_checker import cau_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 in_action,
  input  logic signed [WordBits-1:0] in_a_re,
  input  logic signed [WordBits-1:0] in_a_im,
  input  logic signed [WordBits-1:0] in_b_re,
  input  logic signed [WordBits-1:0] in_b_im,
  input  logic                       out_valid,
  input  logic signed [WordBits-1:0] out_res_re,
  input  logic signed [WordBits-1:0] out_res_im,
  input  logic                       out_overflow,
  input  logic                       out_div_by_zero,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [WordBits-1:0] re;
    logic signed [WordBits-1:0] im;
    logic                       ovf;
    logic                       dbz;
  } cplx_result_t;

  cplx_result_t expected_results[$];

  function automatic logic signed [WordBits-1:0] clamp_word(logic signed [127:0] x,
                                                             inout logic ovf);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = $signed(WORD_MAX);
    lo = -(128'sd1 <<< (WordBits - 1));
    if (x > hi) begin
      ovf = 1'b1;
      return WORD_MAX;
    end else if (x < lo) begin
      ovf = 1'b1;
      return WORD_MIN;
    end
    return x[WordBits-1:0];
  endfunction

  function automatic cplx_result_t complex_op(action_t act, logic signed [WordBits-1:0] ar,
                                              logic signed [WordBits-1:0] ai,
                                              logic signed [WordBits-1:0] br,
                                              logic signed [WordBits-1:0] bi);
    logic signed [127:0] war, wai, wbr, wbi, x_re, x_im, den;
    cplx_result_t r;
    logic ovf;
    war = ar; wai = ai; wbr = br; wbi = bi;
    ovf = 1'b0;
    r.dbz = 1'b0;
    x_re = '0;
    x_im = '0;
    case (act)
      ACT_ADD: begin
        x_re = war + wbr;
        x_im = wai + wbi;
      end
      ACT_SUB: begin
        x_re = war - wbr;
        x_im = wai - wbi;
      end
      ACT_MUL: begin
        // arithmetic shift gives the floor
        x_re = (war * wbr - wai * wbi) >>> FracBits;
        x_im = (wai * wbr + war * wbi) >>> FracBits;
      end
      default: begin
        if (br == 0 && bi == 0) begin
          r.dbz = 1'b1;
        end else begin
          den = wbr * wbr + wbi * wbi;
          // signed division truncates toward zero
          x_re = ((war * wbr + wai * wbi) <<< FracBits) / den;
          x_im = ((wai * wbr - war * wbi) <<< FracBits) / den;
        end
      end
    endcase
    r.re = clamp_word(x_re, ovf);
    r.im = clamp_word(x_im, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    cplx_result_t e;
    if (!rst_n) begin
      errors <= 0;
    end else begin
      if (start && !busy)
        expected_results.push_back(complex_op(action_t'(in_action), in_a_re, in_a_im,
                                              in_b_re, in_b_im));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected result re=%h im=%h", $time, out_res_re, out_res_im);
        end else begin
          e = expected_results.pop_front();
          if (e.re !== out_res_re || e.im !== out_res_im || e.ovf !== out_overflow ||
              e.dbz !== out_div_by_zero) begin
            errors <= errors + 1;
            $display("%0t: mismatch expected re=%h im=%h ovf=%b dbz=%b actual re=%h im=%h ovf=%b dbz=%b",
                     $time, e.re, e.im, e.ovf, e.dbz, out_res_re, out_res_im,
                     out_overflow, out_div_by_zero);
          end
        end
      end
    end
  end

endmodule

/* sim/complex_arith_unit_tb.sv */
// top of the complex arithmetic unit testbench: stimulus and verdict
module complex_arith_unit_tb import cau_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency   = 36;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = ACT_ADD;
  logic signed [WordBits-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid, out_overflow, out_div_by_zero;
  logic signed [WordBits-1:0] out_res_re, out_res_im;
  int errors, pending;
  int cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  complex_arith_unit i_dut (.*);

  complex_arith_unit_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [WordBits-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      4: return $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic issue(action_t act, logic signed [WordBits-1:0] ar,
                       logic signed [WordBits-1:0] ai, logic signed [WordBits-1:0] br,
                       logic signed [WordBits-1:0] bi);
    start <= 1'b1;
    in_action <= act;
    in_a_re <= ar;
    in_a_im <= ai;
    in_b_re <= br;
    in_b_im <= bi;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    logic signed [WordBits-1:0] b_re, b_im;
    action_t act;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes and special cases
    for (int k = 0; k < 4; k++) begin
      act = action_t'(k);
      issue(act, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      issue(act, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      issue(act, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX);
      issue(act, 32'sh0001_0000, -32'sh0000_8000, -32'sh0003_0000, 32'sh0000_0001);
    end
    issue(ACT_DIV, 32'sh0005_0000, -32'sh0002_0000, '0, '0);
    issue(ACT_DIV, WORD_MAX, WORD_MIN, 32'sd1, '0);
    issue(ACT_DIV, 32'sh0001_0000, '0, '0, 32'sh0003_0000);
    issue(ACT_MUL, -32'sd1, -32'sd1, 32'sd1, -32'sd1);
    issue(ACT_MUL, -32'sd3, 32'sd5, 32'sh0000_8000, 32'sd7);
    issue(ACT_ADD, '0, '0, '0, '0);
    issue(ACT_SUB, '0, WORD_MIN, WORD_MIN, '0);

    // let the pipe drain completely once
    idle_for(1);
    wait (pending == 0);
    @(posedge clk);

    for (int n = 0; n < 1950; n++) begin
      act = action_t'($urandom_range(0, 3));
      b_re = pick_word();
      b_im = pick_word();
      if (act == ACT_DIV && $urandom_range(0, 15) == 0) begin
        b_re = '0;
        b_im = '0;
      end
      issue(act, pick_word(), pick_word(), b_re, b_im);
      // bursts with no idle cycles
      if ((n % 300) >= 250) idle_for(0);
      else idle_for(pick_gap());
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
